// ===== design/rlbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rlbs_pkg
// Shared types and constants for the rgb led bit serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlbs_pkg;

  localparam int LEVEL_W   = 8;
  localparam int NIBBLE_W  = 4;
  localparam int UNITS_W   = 4;
  localparam int SYMBOLS   = 24;
  localparam int SYM_IDX_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PULSE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PULSE = 2'd1;

  localparam logic [UNITS_W-1:0] LONG_PULSE_RESET  = 4'd7;
  localparam logic [UNITS_W-1:0] SHORT_PULSE_RESET = 4'd1;

  localparam logic [SYM_IDX_W-1:0] LAST_SYM_IDX = 5'd23;

  // accepted levels are 0..15, so the scaled byte is the level nibble then four zeros
  typedef struct packed {
    logic [NIBBLE_W-1:0] green;
    logic [NIBBLE_W-1:0] red;
    logic [NIBBLE_W-1:0] blue;
  } colour_t;

  typedef struct packed {
    logic [UNITS_W-1:0] long_units;
    logic [UNITS_W-1:0] short_units;
  } pulse_cfg_t;

endpackage

`default_nettype wire

// ===== design/rlbs_front.sv =====
// ----------------------------------------------------------------------------
// rlbs_front
// Range check and change detection; pushes colours that must be sent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlbs_front (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [rlbs_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire                           queue_full,
  output logic                          push,
  output rlbs_pkg::colour_t             push_colour
);
  import rlbs_pkg::*;

  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;
  logic               in_range;
  logic               changed;
  colour_t            req;
  colour_t            sent;
  logic               colour_known;

  assign red_level   = s_tdata[7:0];
  assign green_level = s_tdata[15:8];
  assign blue_level  = s_tdata[23:16];

  assign in_range = (red_level[7:4] == '0) && (green_level[7:4] == '0) &&
                    (blue_level[7:4] == '0);

  always_comb begin
    req.green = green_level[3:0];
    req.red   = red_level[3:0];
    req.blue  = blue_level[3:0];
  end

  assign changed     = !colour_known || (req != sent);
  assign s_tready    = !queue_full;
  assign push        = s_tvalid && s_tready && in_range && changed;
  assign push_colour = req;

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_known <= 1'b0;
      sent         <= '0;
    end else if (push) begin
      colour_known <= 1'b1;
      sent         <= req;
    end
  end

endmodule

`default_nettype wire

// ===== design/rlbs_queue.sv =====
// ----------------------------------------------------------------------------
// rlbs_queue
// Small first-in first-out queue of colours between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlbs_queue #(
  parameter int DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  rlbs_pkg::colour_t  push_colour,
  output logic               full,
  input  wire                pop,
  output rlbs_pkg::colour_t  pop_colour,
  output logic               empty
);
  import rlbs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

  colour_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == FULL_CNT);
  assign empty      = (count == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign pop_colour = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rlbs_back.sv =====
// ----------------------------------------------------------------------------
// rlbs_back
// Shifts a colour out as 24 symbols into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlbs_back (
  input  wire                             clk,
  input  wire                             rst,
  input  rlbs_pkg::pulse_cfg_t            pulse_cfg,
  input  wire                             queue_empty,
  input  rlbs_pkg::colour_t               queue_colour,
  output logic                            pop,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [rlbs_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import rlbs_pkg::*;

  logic [SYMBOLS-1:0]   shreg;
  logic [SYM_IDX_W-1:0] sym_idx;
  logic                 busy;
  logic                 advance;
  logic                 finishing;
  logic                 load;
  logic                 bit_value;
  logic [UNITS_W-1:0]   high_units;
  logic [UNITS_W-1:0]   low_units;
  logic                 last_bit;

  assign advance   = !m_tvalid || m_tready;
  assign finishing = busy && advance && (sym_idx == LAST_SYM_IDX);
  // reload right behind the last symbol so colours run without a gap
  assign load      = !queue_empty && (!busy || finishing);
  assign pop       = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      sym_idx <= '0;
    end else if (load) begin
      busy    <= 1'b1;
      sym_idx <= '0;
    end else if (busy && advance) begin
      busy    <= !finishing;
      sym_idx <= sym_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= {queue_colour.green, 4'b0000, queue_colour.red, 4'b0000,
                queue_colour.blue, 4'b0000};
    end else if (busy && advance) begin
      shreg <= {shreg[SYMBOLS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && busy) begin
      bit_value  <= shreg[SYMBOLS-1];
      high_units <= shreg[SYMBOLS-1] ? pulse_cfg.long_units : pulse_cfg.short_units;
      low_units  <= shreg[SYMBOLS-1] ? pulse_cfg.short_units : pulse_cfg.long_units;
      last_bit   <= (sym_idx == LAST_SYM_IDX);
    end
  end

  assign m_tdata = {7'b0000000, low_units, high_units, bit_value};
  assign m_tlast = last_bit;

endmodule

`default_nettype wire

// ===== design/rgb_led_bit_serializer_top.sv =====
// ----------------------------------------------------------------------------
// rgb_led_bit_serializer_top
// Colour request to led bit symbol serializer with pulse timing registers.
// ----------------------------------------------------------------------------
// A colour transaction carries 4-bit levels (0..15) in 8-bit fields; any level
// above 15 drops the request. A colour equal to the last one sent gives no
// output, except the first one after reset. A sent colour yields 24 symbol
// transactions, one per cycle while the output is taken: green, red, blue,
// msb first, tlast on the 24th. While the queue is not full, requests are taken
// one per cycle into a colour queue of QUEUE_DEPTH entries and the shift stage
// drains it, so a steady stream of changing colours is paced by the output
// register, which sends one symbol per cycle while the output is taken. Pulse
// registers are read as symbols leave, so write them only while idle.
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_bit_serializer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [rlbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [rlbs_pkg::UNITS_W-1:0]     cfg_data,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // red_level[7:0], green_level[15:8], blue_level[23:16]
  input  wire  [rlbs_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // bit_value[0], high_units[4:1], low_units[8:5], zero fill above
  output logic [rlbs_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic                             m_tlast
);
  import rlbs_pkg::*;

  pulse_cfg_t pulse_cfg;
  logic       push;
  colour_t    push_colour;
  logic       queue_full;
  logic       queue_empty;
  logic       pop;
  colour_t    pop_colour;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_cfg.long_units  <= LONG_PULSE_RESET;
      pulse_cfg.short_units <= SHORT_PULSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LONG_PULSE:  pulse_cfg.long_units  <= cfg_data;
        CFG_SHORT_PULSE: pulse_cfg.short_units <= cfg_data;
        default: ;
      endcase
    end
  end

  rlbs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .queue_full  (queue_full),
    .push        (push),
    .push_colour (push_colour)
  );

  rlbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_colour (push_colour),
    .full        (queue_full),
    .pop         (pop),
    .pop_colour  (pop_colour),
    .empty       (queue_empty)
  );

  rlbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pulse_cfg    (pulse_cfg),
    .queue_empty  (queue_empty),
    .queue_colour (pop_colour),
    .pop          (pop),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule

`default_nettype wire
